// File: rtl/qvc_pkg.sv
// qvc_pkg: shared types and codes of the quality value CIGAR decoder.
// No dependencies.
`timescale 1ns / 1ps
package qvc_pkg;

  // Input actions
  localparam logic [2:0] ACT_NEW_BLOCK = 3'd0;
  localparam logic [2:0] ACT_CB_WR     = 3'd1;
  localparam logic [2:0] ACT_POS_WR    = 3'd2;
  localparam logic [2:0] ACT_STEP_WR   = 3'd3;
  localparam logic [2:0] ACT_REC_START = 3'd4;
  localparam logic [2:0] ACT_CIGAR     = 3'd5;
  localparam logic [2:0] ACT_REC_END   = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_QUALITY = 2'd0;
  localparam logic [1:0] KIND_MARKER  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_POS_OFFSET  = 2'd0;
  localparam logic [1:0] REG_QUAL_OFFSET = 2'd1;
  localparam logic [1:0] REG_QUANT_USED  = 2'd2;

  // CIGAR characters
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_X  = 8'h58;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam int         RADIX = 10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_STEP,
    S_SYM,
    S_CB,
    S_ERR
  } dec_state_t;

endpackage

// File: rtl/qvc_ifs.sv
// qvc_ifs: valid/ready channels of the quality value CIGAR decoder.
// No dependencies.
`timescale 1ns / 1ps
interface qvc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  quantizer_sel;
  logic [11:0] address;
  logic [7:0]  value;
  logic [31:0] record_position;
  modport source (output valid, action, quantizer_sel, address, value, record_position,
                  input ready);
  modport sink (input valid, action, quantizer_sel, address, value, record_position,
                output ready);
endinterface

interface qvc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] quality_char;
  logic       last;
  modport source (output valid, kind, quality_char, last, input ready);
  modport sink (input valid, kind, quality_char, last, output ready);
endinterface

// File: rtl/qvc_ram.sv
// qvc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module qvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/quality_value_cigar_decoder_top.sv
// quality_value_cigar_decoder_top: CIGAR-driven quality value decoder.
// Depends on qvc_pkg, qvc_ifs and qvc_ram.
`timescale 1ns / 1ps
// Load items (codebook, position quantizer, step symbol writes), new block, record start,
// record end, digits and operation characters with at most one result stay in S_IDLE.
// Each M, = or X base passes through S_ADDR, S_STEP, S_SYM and S_CB, each I or S base
// through S_STEP, S_SYM and S_CB: the chain of dependent reads (position quantizer store,
// step symbol store, codebook store), each a synchronous memory, sets this, since a base's
// quantizer and step pointer depend on the base before. A bad read ends the run through
// S_ERR. Results leave through an output register, and S_CB and S_ERR wait while it is full;
// one input item is in work at a time. The stores hold no reset value.
module quality_value_cigar_decoder_top #(
  parameter int NUM_QUANTIZERS = 8,
  parameter int CODEBOOK_DEPTH = 16,
  parameter int POSITION_DEPTH = 4096,
  parameter int STEP_DEPTH     = 4096,
  parameter int MAX_RUN        = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  qvc_in_if.sink      in_ch,
  qvc_out_if.source   out_ch
);
  import qvc_pkg::*;

  localparam int CB_ENTRIES = NUM_QUANTIZERS * CODEBOOK_DEPTH;
  localparam int ST_ENTRIES = NUM_QUANTIZERS * STEP_DEPTH;
  localparam int CAW  = $clog2(CB_ENTRIES);
  localparam int PAW  = $clog2(POSITION_DEPTH);
  localparam int SAW  = $clog2(ST_ENTRIES);
  localparam int SPW  = $clog2(STEP_DEPTH + 1);
  localparam int RLW  = $clog2(MAX_RUN + 2);
  localparam int QIW  = (NUM_QUANTIZERS > 1) ? $clog2(NUM_QUANTIZERS) : 1;
  localparam int ACW  = $clog2(NUM_QUANTIZERS + 1);

  // Configuration
  logic [31:0] position_offset;
  logic [7:0]  quality_offset;
  logic [3:0]  quantizers_in_use;

  // Decoder state
  dec_state_t       state, state_next;
  logic [RLW-1:0]   run_length;
  logic [RLW-1:0]   run_cnt;
  logic             matched;
  logic [3:0]       qi_reg;
  logic [31:0]      position_pointer;
  logic [SPW-1:0]   step_ptr [NUM_QUANTIZERS];

  // Memory ports
  logic            cb_we, pq_we, st_we, cb_re, pq_re, st_re;
  logic [CAW-1:0]  cb_waddr, cb_raddr;
  logic [PAW-1:0]  pq_waddr, pq_raddr;
  logic [SAW-1:0]  st_waddr, st_raddr;
  logic [7:0]      cb_rdata;
  logic [3:0]      pq_rdata, st_rdata;

  // Control
  logic            out_free, in_xfer, out_load;
  logic [1:0]      out_kind_next;
  logic [7:0]      out_char_next;
  logic            out_last_next;
  logic [ACW-1:0]  active;
  logic [3:0]      qi_cur;
  logic            step_ok, sym_ok, pos_ok;
  logic [9:0]      digit_sum;
  logic            is_digit, is_match, is_clip, is_skip, is_nop;
  logic            run_over;
  logic            base_done;

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Effective quantizer count
  always_comb begin
    if (quantizers_in_use == 4'd0) begin
      active = ACW'(1);
    end else if (int'(quantizers_in_use) > NUM_QUANTIZERS) begin
      active = ACW'(NUM_QUANTIZERS);
    end else begin
      active = ACW'(quantizers_in_use);
    end
  end

  // Classify the CIGAR byte
  always_comb begin
    is_digit = 1'b0;
    is_match = 1'b0;
    is_clip  = 1'b0;
    is_skip  = 1'b0;
    is_nop   = 1'b0;
    case (in_ch.value) inside
      [CH_0:CH_9]:     is_digit = 1'b1;
      CH_M, CH_EQ, CH_X: is_match = 1'b1;
      CH_I, CH_S:      is_clip  = 1'b1;
      CH_D, CH_N:      is_skip  = 1'b1;
      CH_H, CH_P:      is_nop   = 1'b1;
      default:         is_nop   = 1'b0;
    endcase
  end

  assign run_over  = int'(run_length) > MAX_RUN;
  assign digit_sum = 10'(int'(run_length) * RADIX + int'(in_ch.value - CH_0));

  // Current quantizer and the checks of one base
  assign qi_cur  = matched ? pq_rdata : qi_reg;
  assign pos_ok  = position_pointer < 32'(POSITION_DEPTH);
  assign step_ok = (ACW'(qi_cur) < active) &&
                   (int'(step_ptr[qi_cur[QIW-1:0]]) < STEP_DEPTH);
  assign sym_ok  = int'(st_rdata) < CODEBOOK_DEPTH;
  assign base_done = (state == S_CB) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && in_ch.action == ACT_CIGAR && !is_digit && !run_over &&
            run_length != '0) begin
          if (is_match) begin
            state_next = S_ADDR;
          end else if (is_clip) begin
            state_next = S_STEP;
          end
        end
      end
      S_ADDR:  state_next = pos_ok ? S_STEP : S_ERR;
      S_STEP:  state_next = step_ok ? S_SYM : S_ERR;
      S_SYM:   state_next = sym_ok ? S_CB : S_ERR;
      S_CB: begin
        if (out_free) begin
          if (run_cnt == RLW'(1)) begin
            state_next = S_IDLE;
          end else begin
            state_next = matched ? S_ADDR : S_STEP;
          end
        end
      end
      S_ERR:   state_next = out_free ? S_IDLE : S_ERR;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory accesses and result loading
  always_comb begin
    cb_we = 1'b0;
    pq_we = 1'b0;
    st_we = 1'b0;
    cb_re = 1'b0;
    pq_re = 1'b0;
    st_re = 1'b0;
    cb_waddr = CAW'(int'(in_ch.quantizer_sel) * CODEBOOK_DEPTH + int'(in_ch.address));
    pq_waddr = PAW'(in_ch.address);
    st_waddr = SAW'(int'(in_ch.quantizer_sel) * STEP_DEPTH + int'(in_ch.address));
    pq_raddr = position_pointer[PAW-1:0];
    st_raddr = SAW'(int'(qi_cur) * STEP_DEPTH + int'(step_ptr[qi_cur[QIW-1:0]]));
    cb_raddr = CAW'(int'(qi_reg) * CODEBOOK_DEPTH + int'(st_rdata));
    out_load      = 1'b0;
    out_kind_next = KIND_QUALITY;
    out_char_next = 8'd0;
    out_last_next = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.action)
            ACT_CB_WR: cb_we = (int'(in_ch.quantizer_sel) < NUM_QUANTIZERS) &&
                               (int'(in_ch.address) < CODEBOOK_DEPTH);
            ACT_POS_WR: pq_we = int'(in_ch.address) < POSITION_DEPTH;
            ACT_STEP_WR: st_we = (int'(in_ch.quantizer_sel) < NUM_QUANTIZERS) &&
                                 (int'(in_ch.address) < STEP_DEPTH);
            ACT_CIGAR: begin
              if (!is_digit && (run_over ||
                  !(is_match || is_clip || is_skip || is_nop))) begin
                out_load      = 1'b1;
                out_kind_next = KIND_ERROR;
              end
            end
            ACT_REC_END: begin
              out_load      = 1'b1;
              out_kind_next = KIND_MARKER;
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      S_ADDR: pq_re = pos_ok;
      S_STEP: st_re = step_ok;
      S_SYM:  cb_re = sym_ok;
      S_CB: begin
        out_load      = out_free;
        out_char_next = cb_rdata + quality_offset;
        out_last_next = run_cnt == RLW'(1);
      end
      S_ERR: begin
        out_load      = out_free;
        out_kind_next = KIND_ERROR;
      end
      default: out_load = 1'b0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      position_offset   <= 32'd0;
      quality_offset    <= 8'd33;
      quantizers_in_use <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_OFFSET:  position_offset   <= cfg_data;
        REG_QUAL_OFFSET: quality_offset    <= cfg_data[7:0];
        REG_QUANT_USED:  quantizers_in_use <= cfg_data[3:0];
        default:         quantizers_in_use <= quantizers_in_use;
      endcase
    end
  end

  // Decoder registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      run_length       <= '0;
      run_cnt          <= '0;
      matched          <= 1'b0;
      qi_reg           <= 4'd0;
      position_pointer <= 32'd0;
      for (int q = 0; q < NUM_QUANTIZERS; q++) begin
        step_ptr[q] <= '0;
      end
    end else begin
      state <= state_next;
      if (in_xfer) begin
        case (in_ch.action)
          ACT_NEW_BLOCK: begin
            run_length       <= '0;
            position_pointer <= 32'd0;
            for (int q = 0; q < NUM_QUANTIZERS; q++) begin
              step_ptr[q] <= '0;
            end
          end
          ACT_REC_START: begin
            run_length       <= '0;
            position_pointer <= in_ch.record_position - position_offset;
          end
          ACT_CIGAR: begin
            if (is_digit) begin
              run_length <= (int'(digit_sum) > MAX_RUN) ? RLW'(MAX_RUN + 1)
                                                        : RLW'(digit_sum);
            end else begin
              run_length <= '0;
              run_cnt    <= run_length;
              matched    <= is_match;
              qi_reg     <= 4'(int'(active) - 1);
              if (is_skip && !run_over) begin
                position_pointer <= position_pointer + 32'(run_length);
              end
            end
          end
          ACT_REC_END: run_length <= '0;
          default: run_length <= run_length;
        endcase
      end
      // Latch the quantizer of the base
      if (state == S_STEP) begin
        qi_reg <= qi_cur;
      end
      // Advance pointers when a base is delivered
      if (base_done) begin
        run_cnt <= run_cnt - RLW'(1);
        step_ptr[qi_reg[QIW-1:0]] <= step_ptr[qi_reg[QIW-1:0]] + SPW'(1);
        if (matched) begin
          position_pointer <= position_pointer + 32'd1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.kind         <= out_kind_next;
      out_ch.quality_char <= out_char_next;
      out_ch.last         <= out_last_next;
    end
  end

  // Stores
  qvc_ram #(.WIDTH(8), .DEPTH(CB_ENTRIES)) u_codebook (
    .clk(clk), .we(cb_we), .waddr(cb_waddr), .wdata(in_ch.value),
    .re(cb_re), .raddr(cb_raddr), .rdata(cb_rdata)
  );

  qvc_ram #(.WIDTH(4), .DEPTH(POSITION_DEPTH)) u_pos_quant (
    .clk(clk), .we(pq_we), .waddr(pq_waddr), .wdata(in_ch.value[3:0]),
    .re(pq_re), .raddr(pq_raddr), .rdata(pq_rdata)
  );

  qvc_ram #(.WIDTH(4), .DEPTH(ST_ENTRIES)) u_step_sym (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(in_ch.value[3:0]),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  // A waiting non-final quality means the run is still in work
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind == KIND_QUALITY && !out_ch.last |-> state != S_IDLE)
    else $error("non-final quality with decoder idle");

  // Marker and error results carry a zero character
  a_zero_char: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind != KIND_QUALITY |-> out_ch.quality_char == 8'd0)
    else $error("nonzero character on marker or error");

  // A codebook read follows only a step symbol read
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CB && $past(state) != S_CB |-> $past(state) == S_SYM)
    else $error("codebook read out of order");

endmodule

// File: tb/testbench.sv
// testbench: self-checking regression of quality_value_cigar_decoder_top.
// Depends on qvc_pkg, qvc_ifs and the decoder RTL; predicts every result in a scoreboard class.
`timescale 1ns / 1ps
module testbench;
  import qvc_pkg::*;

  localparam int NQ = 8;
  localparam int CB_DEPTH = 16;
  localparam int POS_DEPTH = 4096;
  localparam int STEP_DEPTH = 4096;
  localparam int RUN_MAX = 64;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] quality_char;
    logic       last;
  } qv_result_t;

  // Tracks decoder state and holds the qualities still to come out
  class quality_scoreboard;
    logic [31:0] pos_off;
    logic [7:0]  qual_off;
    logic [3:0]  quant_used;
    int unsigned run_len;
    logic [31:0] pos_ptr;
    logic [31:0] step_ptr[NQ];
    logic [7:0]  codebook[NQ*CB_DEPTH];
    bit          codebook_ok[NQ*CB_DEPTH];
    logic [3:0]  pos_quant[POS_DEPTH];
    bit          pos_quant_ok[POS_DEPTH];
    logic [3:0]  step_sym[NQ*STEP_DEPTH];
    bit          step_sym_ok[NQ*STEP_DEPTH];
    qv_result_t  pending_results[$];
    int          errors;

    function new();
      pos_off = 0;
      qual_off = 8'd33;
      quant_used = 4'd1;
      run_len = 0;
      pos_ptr = 0;
      errors = 0;
      foreach (step_ptr[i]) step_ptr[i] = 0;
      foreach (codebook_ok[i]) codebook_ok[i] = 0;
      foreach (pos_quant_ok[i]) pos_quant_ok[i] = 0;
      foreach (step_sym_ok[i]) step_sym_ok[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_POS_OFFSET:  pos_off = data;
        REG_QUAL_OFFSET: qual_off = data[7:0];
        REG_QUANT_USED:  quant_used = data[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_quants();
      if (quant_used == 0) return 1;
      if (quant_used > NQ) return NQ;
      return 32'(quant_used);
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] q);
      qv_result_t r;
      r.kind = kind;
      r.quality_char = q;
      r.last = 1'b0;
      pending_results = {pending_results, r};
    endfunction

    // Walk a run of bases; with apply clear only report whether every read hits written data
    function bit decode_run(bit matched, bit apply);
      logic [31:0] p;
      logic [31:0] sp[NQ];
      int unsigned i, qi, s;
      bit clean, bad;
      logic [7:0] q;
      clean = 1;
      bad = 0;
      p = pos_ptr;
      foreach (sp[k]) sp[k] = step_ptr[k];
      for (i = 0; i < run_len; i++) begin
        if (matched) begin
          if (p >= POS_DEPTH) begin
            bad = 1;
            break;
          end
          if (!pos_quant_ok[p]) clean = 0;
          qi = 32'(pos_quant[p]);
        end else begin
          qi = active_quants() - 1;
        end
        if (qi >= active_quants() || sp[qi] >= STEP_DEPTH) begin
          bad = 1;
          break;
        end
        if (!step_sym_ok[qi*STEP_DEPTH + sp[qi]]) clean = 0;
        s = 32'(step_sym[qi*STEP_DEPTH + sp[qi]]);
        if (s >= CB_DEPTH) begin
          bad = 1;
          break;
        end
        if (!codebook_ok[qi*CB_DEPTH + s]) clean = 0;
        q = codebook[qi*CB_DEPTH + s] + qual_off;
        sp[qi] = sp[qi] + 1;
        if (matched) p = p + 1;
        if (apply) push_result(KIND_QUALITY, q);
      end
      if (apply) begin
        if (bad) push_result(KIND_ERROR, 8'd0);
        pos_ptr = p;
        foreach (sp[k]) step_ptr[k] = sp[k];
      end
      return clean;
    endfunction

    function bit is_match(logic [7:0] c);
      return c == CH_M || c == CH_EQ || c == CH_X;
    endfunction

    function bit is_clip(logic [7:0] c);
      return c == CH_I || c == CH_S;
    endfunction

    // True when an operation char would touch no unwritten store entry
    function bit op_safe(logic [7:0] c);
      if (run_len > RUN_MAX) return 1;
      if (is_match(c)) return decode_run(1, 0);
      if (is_clip(c)) return decode_run(0, 0);
      return 1;
    endfunction

    function void note_input(logic [2:0] act, logic [2:0] sel, logic [11:0] addr,
                             logic [7:0] val, logic [31:0] rpos);
      int n0;
      logic [3:0] sym;
      n0 = pending_results.size();
      sym = 4'(val - CH_0);
      case (act)
        ACT_NEW_BLOCK: begin
          run_len = 0;
          pos_ptr = 0;
          foreach (step_ptr[k]) step_ptr[k] = 0;
        end
        ACT_CB_WR: if (addr < CB_DEPTH) begin
          codebook[sel*CB_DEPTH + addr] = val;
          codebook_ok[sel*CB_DEPTH + addr] = 1;
        end
        ACT_POS_WR: begin
          pos_quant[addr] = sym;
          pos_quant_ok[addr] = 1;
        end
        ACT_STEP_WR: begin
          step_sym[sel*STEP_DEPTH + addr] = sym;
          step_sym_ok[sel*STEP_DEPTH + addr] = 1;
        end
        ACT_REC_START: begin
          pos_ptr = rpos - pos_off;
          run_len = 0;
        end
        ACT_CIGAR: begin
          if (val >= CH_0 && val <= CH_9) begin
            run_len = run_len * RADIX + (val - CH_0);
            if (run_len > RUN_MAX) run_len = RUN_MAX + 1;
          end else begin
            if (run_len > RUN_MAX) push_result(KIND_ERROR, 8'd0);
            else if (is_match(val)) void'(decode_run(1, 1));
            else if (is_clip(val)) void'(decode_run(0, 1));
            else if (val == CH_D || val == CH_N) pos_ptr = pos_ptr + run_len;
            else if (val != CH_H && val != CH_P) push_result(KIND_ERROR, 8'd0);
            run_len = 0;
          end
        end
        ACT_REC_END: begin
          run_len = 0;
          push_result(KIND_MARKER, 8'd0);
        end
        default: ;
      endcase
      if (pending_results.size() > n0) pending_results[$].last = 1'b1;
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [7:0] q, logic last);
      qv_result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d q %0d", kind, q));
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind)
        report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
      if (q !== e.quality_char)
        report_mismatch($sformatf("quality %0d, want %0d", q, e.quality_char));
      if (last !== e.last)
        report_mismatch($sformatf("last %0d, want %0d", last, e.last));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  qvc_in_if  in_ch ();
  qvc_out_if out_ch ();

  quality_value_cigar_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  quality_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int sent_items = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Drive receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Check each result transfer and watch for a hang
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.kind, out_ch.quality_char, out_ch.last);
    if (!rst && ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)))
      idle_cycles = 0;
    else if (!rst)
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("quality_value_cigar_decoder_top regression: fail");
      $finish;
    end
  end

  task send_item(logic [2:0] act, logic [2:0] sel, logic [11:0] addr,
                 logic [7:0] val, logic [31:0] rpos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.quantizer_sel <= sel;
    in_ch.address <= addr;
    in_ch.value <= val;
    in_ch.record_position <= rpos;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(act, sel, addr, val, rpos);
    sent_items++;
  endtask

  task send_cigar(logic [7:0] c);
    send_item(ACT_CIGAR, 3'd0, 12'd0, c, 32'd0);
  endtask

  // Send a run length and an operation; swap in a deletion where data was never loaded
  task send_op(int len, logic [7:0] c);
    string digits;
    logic [7:0] op;
    int i;
    digits = (len < 0) ? "" : $sformatf("%0d", len);
    for (i = 0; i < digits.len(); i++) send_cigar(digits[i]);
    op = sb.op_safe(c) ? c : CH_D;
    send_cigar(op);
  endtask

  // One write, then the write enable drops before the next one, so back-to-back writes never overlap
  task write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Hold the input, let every expected result arrive, then settle
  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task random_traffic(int n_items);
    int start, r, k, len, j;
    logic [7:0] ops[9];
    ops = '{CH_M, CH_EQ, CH_X, CH_I, CH_S, CH_D, CH_N, CH_H, CH_P};
    start = sent_items;
    while (sent_items - start < n_items) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_item(ACT_NEW_BLOCK, 3'($urandom), 12'($urandom), 8'($urandom), $urandom);
      end else if (r < 12) begin
        case ($urandom_range(2))
          0: send_item(ACT_CB_WR, 3'($urandom), 12'($urandom_range(31)), 8'($urandom),
                       $urandom);
          1: send_item(ACT_POS_WR, 3'($urandom), 12'($urandom_range(31)), 8'($urandom),
                       $urandom);
          default: send_item(ACT_STEP_WR, 3'($urandom), 12'($urandom_range(63)),
                             8'($urandom), $urandom);
        endcase
      end else if (r < 14) begin
        send_item(3'd7, 3'($urandom), 12'($urandom), 8'($urandom), $urandom);
      end else if (r < 17) begin
        send_cigar(8'($urandom));
      end else begin
        if ($urandom_range(9) == 0)
          send_item(ACT_REC_START, 3'd0, 12'd0, 8'd0, $urandom);
        else
          send_item(ACT_REC_START, 3'd0, 12'd0, 8'd0, sb.pos_off + $urandom_range(20));
        k = $urandom_range(4, 1);
        for (j = 0; j < k; j++) begin
          r = $urandom_range(99);
          if (r < 80) len = $urandom_range(6, 1);
          else if (r < 90) len = $urandom_range(64, 7);
          else if (r < 95) len = $urandom_range(200, 65);
          else len = -1;
          send_op(len, ops[$urandom_range(8)]);
        end
        send_item(ACT_REC_END, 3'd0, 12'd0, 8'd0, 32'd0);
      end
    end
  endtask

  initial begin
    int i, q;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.quantizer_sel = '0;
    in_ch.address = '0;
    in_ch.value = '0;
    in_ch.record_position = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_POS_OFFSET, 32'd0);
    write_reg(REG_QUAL_OFFSET, 32'd0);
    write_reg(REG_QUANT_USED, 32'd8);

    // Load the low codebook entries, the first positions and the first step slots
    for (q = 0; q < NQ; q++)
      for (i = 0; i < 4; i++)
        send_item(ACT_CB_WR, 3'(q), 12'(i), 8'($urandom), $urandom);
    for (i = 0; i < 16; i++)
      send_item(ACT_POS_WR, 3'($urandom), 12'(i), 8'(CH_0 + $urandom_range(9)), $urandom);
    for (q = 0; q < NQ; q++)
      for (i = 0; i < ((q == NQ - 1) ? RUN_MAX : 6); i++)
        send_item(ACT_STEP_WR, 3'(q), 12'(i), 8'(CH_0 + $urandom_range(3)), $urandom);

    // Directed: every operation, extremes and error cases
    send_item(ACT_REC_START, 3'd0, 12'd0, 8'd0, 32'd0);
    send_op(3, CH_M);
    send_op(2, CH_EQ);
    send_op(-1, CH_X);
    send_op(4, CH_I);
    send_op(-1, CH_S);
    send_op(5, CH_D);
    send_op(-1, CH_N);
    send_op(3, CH_H);
    send_op(-1, CH_P);
    send_item(ACT_NEW_BLOCK, 3'd0, 12'd0, 8'd0, 32'd0);
    send_item(ACT_REC_START, 3'd0, 12'd0, 8'd0, 32'd0);
    send_op(64, CH_S);
    send_op(99, CH_M);
    send_op(0, CH_M);
    send_cigar(8'h5A);
    send_cigar(8'hFF);
    send_item(ACT_REC_END, 3'd0, 12'd0, 8'd0, 32'd0);
    send_item(3'd7, 3'd7, 12'hFFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(ACT_CB_WR, 3'd7, 12'hFFF, 8'hFF, 32'd0);
    send_item(ACT_CB_WR, 3'd7, 12'd15, 8'hFF, 32'd0);
    send_item(ACT_STEP_WR, 3'd7, 12'hFFF, 8'hFF, 32'd0);
    send_item(ACT_POS_WR, 3'd0, 12'hFFF, 8'h00, 32'd0);
    send_item(ACT_NEW_BLOCK, 3'd0, 12'd0, 8'd0, 32'd0);
    send_item(ACT_REC_START, 3'd0, 12'd0, 8'd0, 32'hFFFF_FFFF);
    send_op(2, CH_M);
    send_item(ACT_REC_END, 3'd0, 12'd0, 8'd0, 32'd0);
    drain();

    // Random phases across register settings and idle patterns
    random_traffic(25);
    drain();
    write_reg(REG_POS_OFFSET, 32'hFFFF_FFFF);
    write_reg(REG_QUAL_OFFSET, 32'd255);
    write_reg(REG_QUANT_USED, 32'd0);
    in_idle_pct = 81;
    random_traffic(25);
    drain();
    write_reg(REG_POS_OFFSET, $urandom);
    write_reg(REG_QUAL_OFFSET, $urandom_range(255));
    write_reg(REG_QUANT_USED, 32'd15);
    in_idle_pct = 0;
    out_stall_pct = 81;
    random_traffic(25);
    drain();
    write_reg(REG_QUANT_USED, 32'd3);
    in_idle_pct = 34;
    out_stall_pct = 34;
    random_traffic(25);
    drain();

    // Back-pressure: receiver holds off while the sender keeps offering runs
    write_reg(REG_QUANT_USED, 32'd8);
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_item(ACT_NEW_BLOCK, 3'd0, 12'd0, 8'd0, 32'd0);
    hold_req = 1;
    random_traffic(25);
    drain();
    repeat (60) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("quality_value_cigar_decoder_top regression: pass");
    end else begin
      $display("quality_value_cigar_decoder_top regression: fail");
    end
    $finish;
  end
endmodule
